// ===== hdl/kbh_pkg.sv =====
// shared types and constants of the k-best candidate heap
package kbh_pkg;

    // field widths fixed by the item format
    localparam int DIST_W      = 32;
    localparam int OP_W        = 2;
    localparam int STATUS_W    = 3;
    localparam int K_CFG_W     = 5;
    localparam int IN_USER_W   = OP_W + 1;

    // reset value of the k register
    localparam logic [K_CFG_W-1:0] K_RESET = 5'd16;

    // operation codes
    localparam logic [OP_W-1:0] OP_START   = 2'd0;
    localparam logic [OP_W-1:0] OP_FILL    = 2'd1;
    localparam logic [OP_W-1:0] OP_ATTEMPT = 2'd2;
    localparam logic [OP_W-1:0] OP_DRAIN   = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_ACCEPTED   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_UNUSABLE   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_CLOSER = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL       = 3'd4;
    localparam logic [STATUS_W-1:0] ST_ENTRY      = 3'd5;

    // commands from the controller to the datapath
    typedef struct packed {
        logic                take_in;      // capture input item, clear scan state
        logic                count_clear;  // empty the heap
        logic                scan_rd;      // read two entries at pos, pos += 2
        logic                scan_cmp;     // compare the pair with the candidate
        logic                ins_open;     // hole at end of heap, count++
        logic                rm_open;      // count--, read last entry
        logic                mov_load;     // latch last entry, hole at root
        logic                up_rd;        // read parent of hole
        logic                up_move;      // parent moves down into hole
        logic                up_place;     // candidate written into hole
        logic                dn_rd;        // read both children of hole
        logic                dn_move;      // larger child moves up into hole
        logic                dn_place;     // moving entry written into hole
        logic                drn_rd;       // read entry at pos
        logic                drn_out;      // load drained entry into output, pos++
        logic                res_out;      // load status result into output
        logic [STATUS_W-1:0] res_status;
    } kbh_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            usable;
        logic            dup;
        logic            cnt_zero;
        logic            below_k;
        logic            closer;
        logic            scan_done;
        logic            hole_root;
        logic            parent_less;
        logic            dn_leaf;
        logic            dn_stay;
        logic            drn_last;
        logic            out_free;
    } kbh_stat_t;

endpackage

// ===== hdl/kbh_ctrl.sv =====
// controller state machine of the k-best candidate heap
module kbh_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  kbh_pkg::kbh_stat_t stat,
    output kbh_pkg::kbh_cmd_t  cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DISPATCH = 4'd1;
    localparam logic [3:0] S_SCAN_RD  = 4'd2;
    localparam logic [3:0] S_SCAN_CMP = 4'd3;
    localparam logic [3:0] S_DECIDE   = 4'd4;
    localparam logic [3:0] S_MOV      = 4'd5;
    localparam logic [3:0] S_DN_RD    = 4'd6;
    localparam logic [3:0] S_DN_CMP   = 4'd7;
    localparam logic [3:0] S_UP_RD    = 4'd8;
    localparam logic [3:0] S_UP_CMP   = 4'd9;
    localparam logic [3:0] S_RESULT   = 4'd10;
    localparam logic [3:0] S_DRN_RD   = 4'd11;
    localparam logic [3:0] S_DRN_OUT  = 4'd12;

    logic [3:0]                    state_reg;
    logic [3:0]                    state_next;
    logic [kbh_pkg::STATUS_W-1:0]  st_reg;
    logic [kbh_pkg::STATUS_W-1:0]  st_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // pending status of the current item
    always_ff @(posedge clk)
    begin
        st_reg <= st_next;
    end

    assign in_ready = (state_reg == S_IDLE);

    // next state and commands
    always_comb
    begin
        state_next     = state_reg;
        st_next        = st_reg;
        cmd            = '0;
        cmd.res_status = st_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take_in = 1'b1;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (stat.op == kbh_pkg::OP_START)
                begin
                    cmd.count_clear = 1'b1;
                    st_next         = kbh_pkg::ST_ACCEPTED;
                    state_next      = S_RESULT;
                end
                else if (stat.op == kbh_pkg::OP_DRAIN)
                begin
                    state_next = stat.cnt_zero ? S_IDLE : S_DRN_RD;
                end
                else
                begin
                    state_next = stat.cnt_zero ? S_DECIDE : S_SCAN_RD;
                end
            end
            S_SCAN_RD:
            begin
                cmd.scan_rd = 1'b1;
                state_next  = S_SCAN_CMP;
            end
            S_SCAN_CMP:
            begin
                cmd.scan_cmp = 1'b1;
                state_next   = stat.scan_done ? S_DECIDE : S_SCAN_RD;
            end
            S_DECIDE:
            begin
                if (stat.dup)
                begin
                    st_next    = kbh_pkg::ST_DUPLICATE;
                    state_next = S_RESULT;
                end
                else if (!stat.usable)
                begin
                    st_next    = kbh_pkg::ST_UNUSABLE;
                    state_next = S_RESULT;
                end
                else if (stat.below_k)
                begin
                    cmd.ins_open = 1'b1;
                    st_next      = kbh_pkg::ST_ACCEPTED;
                    state_next   = S_UP_RD;
                end
                else if (stat.op == kbh_pkg::OP_FILL)
                begin
                    st_next    = kbh_pkg::ST_FULL;
                    state_next = S_RESULT;
                end
                else if (stat.closer)
                begin
                    cmd.rm_open = 1'b1;
                    st_next     = kbh_pkg::ST_ACCEPTED;
                    state_next  = S_MOV;
                end
                else
                begin
                    st_next    = kbh_pkg::ST_NOT_CLOSER;
                    state_next = S_RESULT;
                end
            end
            S_MOV:
            begin
                cmd.mov_load = 1'b1;
                state_next   = S_DN_RD;
            end
            S_DN_RD:
            begin
                if (stat.dn_leaf)
                begin
                    cmd.dn_place = 1'b1;
                    cmd.ins_open = 1'b1;
                    state_next   = S_UP_RD;
                end
                else
                begin
                    cmd.dn_rd  = 1'b1;
                    state_next = S_DN_CMP;
                end
            end
            S_DN_CMP:
            begin
                if (stat.dn_stay)
                begin
                    cmd.dn_place = 1'b1;
                    cmd.ins_open = 1'b1;
                    state_next   = S_UP_RD;
                end
                else
                begin
                    cmd.dn_move = 1'b1;
                    state_next  = S_DN_RD;
                end
            end
            S_UP_RD:
            begin
                if (stat.hole_root)
                begin
                    cmd.up_place = 1'b1;
                    state_next   = S_RESULT;
                end
                else
                begin
                    cmd.up_rd  = 1'b1;
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP:
            begin
                if (stat.parent_less)
                begin
                    cmd.up_move = 1'b1;
                    state_next  = S_UP_RD;
                end
                else
                begin
                    cmd.up_place = 1'b1;
                    state_next   = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (stat.out_free)
                begin
                    cmd.res_out = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_DRN_RD:
            begin
                cmd.drn_rd = 1'b1;
                state_next = S_DRN_OUT;
            end
            S_DRN_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.drn_out = 1'b1;
                    state_next  = stat.drn_last ? S_IDLE : S_DRN_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/kbh_datapath.sv =====
// heap memory, scan and sift datapath and output register of the candidate heap
module kbh_datapath #(
    parameter int MAX_K      = 16,
    parameter int COORD_BITS = 12,
    localparam int IDX_W     = (MAX_K > 1) ? $clog2(MAX_K) : 1,
    localparam int CNT_W     = $clog2(MAX_K + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [CNT_W-1:0]              k_eff,
    input  logic [kbh_pkg::OP_W-1:0]      in_op,
    input  logic [COORD_BITS-1:0]         in_x,
    input  logic [COORD_BITS-1:0]         in_y,
    input  logic [kbh_pkg::DIST_W-1:0]    in_d,
    input  logic                          in_usable,
    input  kbh_pkg::kbh_cmd_t             cmd,
    output kbh_pkg::kbh_stat_t            stat,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [kbh_pkg::STATUS_W-1:0]  out_status,
    output logic [COORD_BITS-1:0]         out_x,
    output logic [COORD_BITS-1:0]         out_y,
    output logic [kbh_pkg::DIST_W-1:0]    out_d,
    output logic                          out_last
);

    localparam int PW = CNT_W + 1;

    typedef struct packed {
        logic [kbh_pkg::DIST_W-1:0] d;
        logic [COORD_BITS-1:0]      x;
        logic [COORD_BITS-1:0]      y;
    } entry_t;

    entry_t                       heap_mem [MAX_K];
    entry_t                       rd_a_reg;
    entry_t                       rd_b_reg;
    entry_t                       mov_reg;
    entry_t                       cand;
    entry_t                       wr_data;
    logic                         wr_en;
    logic [IDX_W-1:0]             wr_addr;
    logic                         rd_a_en;
    logic                         rd_b_en;
    logic [IDX_W-1:0]             rd_a_addr;
    logic [IDX_W-1:0]             rd_b_addr;

    logic [kbh_pkg::OP_W-1:0]     op_reg;
    logic [COORD_BITS-1:0]        cx_reg;
    logic [COORD_BITS-1:0]        cy_reg;
    logic [kbh_pkg::DIST_W-1:0]   cd_reg;
    logic                         usable_reg;
    logic [kbh_pkg::DIST_W-1:0]   root_d_reg;
    logic [CNT_W-1:0]             count_reg;
    logic [PW-1:0]                pos_reg;
    logic [IDX_W-1:0]             hole_reg;
    logic                         dup_reg;

    logic                         out_valid_reg;
    logic [kbh_pkg::STATUS_W-1:0] out_status_reg;
    entry_t                       out_ent_reg;
    logic                         out_last_reg;
    logic                         out_load;
    logic                         out_free;

    logic [IDX_W-1:0]             parent;
    logic [PW-1:0]                lc;
    logic [PW-1:0]                rc;
    logic                         r_ok;
    logic                         pick_left;
    logic                         pick_right;
    logic [kbh_pkg::DIST_W-1:0]   pick_d;
    logic                         b_ok;
    logic                         hit_a;
    logic                         hit_b;

    assign cand = '{d: cd_reg, x: cx_reg, y: cy_reg};

    // tree navigation around the hole
    assign parent = (hole_reg - IDX_W'(1)) >> 1;
    assign lc     = (PW'(hole_reg) << 1) + PW'(1);
    assign rc     = (PW'(hole_reg) << 1) + PW'(2);
    assign r_ok   = rc < PW'(count_reg);

    // sift-down child pick, left first then right on strict compare
    assign pick_left  = mov_reg.d < rd_a_reg.d;
    assign pick_d     = pick_left ? rd_a_reg.d : mov_reg.d;
    assign pick_right = r_ok && (pick_d < rd_b_reg.d);

    // duplicate match on the pair just read
    assign b_ok  = (pos_reg - PW'(1)) < PW'(count_reg);
    assign hit_a = (rd_a_reg.x == cx_reg) && (rd_a_reg.y == cy_reg);
    assign hit_b = b_ok && (rd_b_reg.x == cx_reg) && (rd_b_reg.y == cy_reg);

    // memory port selection
    always_comb
    begin
        wr_en     = cmd.up_move | cmd.up_place | cmd.dn_move | cmd.dn_place;
        wr_addr   = hole_reg;
        wr_data   = cand;
        if (cmd.up_move)
        begin
            wr_data = rd_a_reg;
        end
        else if (cmd.dn_move)
        begin
            wr_data = pick_right ? rd_b_reg : rd_a_reg;
        end
        else if (cmd.dn_place)
        begin
            wr_data = mov_reg;
        end

        rd_a_en   = cmd.scan_rd | cmd.rm_open | cmd.up_rd | cmd.dn_rd | cmd.drn_rd;
        rd_b_en   = cmd.scan_rd | cmd.dn_rd;
        rd_a_addr = IDX_W'(pos_reg);
        rd_b_addr = IDX_W'(pos_reg + PW'(1));
        if (cmd.rm_open)
        begin
            rd_a_addr = IDX_W'(count_reg - CNT_W'(1));
        end
        else if (cmd.up_rd)
        begin
            rd_a_addr = parent;
        end
        else if (cmd.dn_rd)
        begin
            rd_a_addr = IDX_W'(lc);
            rd_b_addr = IDX_W'(rc);
        end
    end

    // heap memory, one write and two registered reads
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            heap_mem[wr_addr] <= wr_data;
        end
        if (rd_a_en)
        begin
            rd_a_reg <= heap_mem[rd_a_addr];
        end
        if (rd_b_en)
        begin
            rd_b_reg <= heap_mem[rd_b_addr];
        end
    end

    // item capture, root distance and moving entry
    always_ff @(posedge clk)
    begin
        if (cmd.take_in)
        begin
            op_reg     <= in_op;
            cx_reg     <= in_x;
            cy_reg     <= in_y;
            cd_reg     <= in_d;
            usable_reg <= in_usable;
        end
        if (cmd.scan_cmp && (pos_reg == PW'(2)))
        begin
            root_d_reg <= rd_a_reg.d;
        end
        if (cmd.mov_load)
        begin
            mov_reg <= rd_a_reg;
        end
    end

    // heap count, scan position, hole and duplicate flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            pos_reg   <= '0;
            hole_reg  <= '0;
            dup_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.count_clear)
            begin
                count_reg <= '0;
            end
            else if (cmd.ins_open)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (cmd.rm_open)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end

            if (cmd.take_in)
            begin
                pos_reg <= '0;
            end
            else if (cmd.scan_rd)
            begin
                pos_reg <= pos_reg + PW'(2);
            end
            else if (cmd.drn_out)
            begin
                pos_reg <= pos_reg + PW'(1);
            end

            if (cmd.ins_open)
            begin
                hole_reg <= IDX_W'(count_reg);
            end
            else if (cmd.mov_load)
            begin
                hole_reg <= '0;
            end
            else if (cmd.up_move)
            begin
                hole_reg <= parent;
            end
            else if (cmd.dn_move)
            begin
                hole_reg <= pick_right ? IDX_W'(rc) : IDX_W'(lc);
            end

            if (cmd.take_in)
            begin
                dup_reg <= 1'b0;
            end
            else if (cmd.scan_cmp)
            begin
                dup_reg <= dup_reg | hit_a | hit_b;
            end
        end
    end

    // output register, freed when the held result is taken
    assign out_free = !out_valid_reg || out_ready;
    assign out_load = cmd.res_out | cmd.drn_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.drn_out)
        begin
            out_status_reg <= kbh_pkg::ST_ENTRY;
            out_ent_reg    <= rd_a_reg;
            out_last_reg   <= stat.drn_last;
        end
        else if (cmd.res_out)
        begin
            out_status_reg <= cmd.res_status;
            out_ent_reg    <= '0;
            out_last_reg   <= 1'b1;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_x      = out_ent_reg.x;
    assign out_y      = out_ent_reg.y;
    assign out_d      = out_ent_reg.d;
    assign out_last   = out_last_reg;

    // status to the controller
    always_comb
    begin
        stat             = '0;
        stat.op          = op_reg;
        stat.usable      = usable_reg;
        stat.dup         = dup_reg;
        stat.cnt_zero    = (count_reg == '0);
        stat.below_k     = count_reg < k_eff;
        stat.closer      = cd_reg < root_d_reg;
        stat.scan_done   = pos_reg >= PW'(count_reg);
        stat.hole_root   = (hole_reg == '0);
        stat.parent_less = rd_a_reg.d < cd_reg;
        stat.dn_leaf     = lc >= PW'(count_reg);
        stat.dn_stay     = !pick_left && !pick_right;
        stat.drn_last    = (pos_reg + PW'(1)) == PW'(count_reg);
        stat.out_free    = out_free;
    end

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_K))
        else $error("heap count above capacity");

    a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.up_move, cmd.up_place, cmd.dn_move, cmd.dn_place}))
        else $error("two heap writes in one cycle");

    a_drain_inside: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.drn_out |-> (pos_reg < PW'(count_reg)))
        else $error("drain beyond heap count");

    a_out_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> out_free)
        else $error("output register overwritten while held");

endmodule

// ===== hdl/k_best_candidate_heap_core.sv =====
// top level of the k-best candidate heap: stream ports, k register, controller and datapath
//
// Keeps up to k (distance, x, y) candidates as a max-heap in a small memory with one
// write port and two registered read ports; one item is processed at a time. A start
// clears the heap; a fill or attempt first scans a non-empty heap for a duplicate,
// reading two entries per step; an insert then sifts the new entry up, and a root
// replace first moves the last entry to the root and sifts it down before the sift-up.
// Each step registers its memory read and then compares, ahead of the single write
// port. Drain reads and loads one entry at a time, each load waiting for a free output
// register; an empty heap drains with no result. The next item can be taken in the
// cycle after a result is loaded, even while that result still waits on m_tready.
module k_best_candidate_heap_core #(
    parameter int MAX_K       = 16,
    parameter int COORD_BITS  = 12,
    localparam int CNT_W      = $clog2(MAX_K + 1),
    localparam int IN_DATA_W  = ((2 * COORD_BITS + kbh_pkg::DIST_W + 7) / 8) * 8,
    localparam int OUT_DATA_W = ((2 * COORD_BITS + kbh_pkg::DIST_W + 7) / 8) * 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // cand_x, cand_y, cand_distance
    input  logic [IN_DATA_W-1:0]            s_tdata,
    // operation, cand_usable
    input  logic [kbh_pkg::IN_USER_W-1:0]   s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // entry_x, entry_y, entry_distance
    output logic [OUT_DATA_W-1:0]           m_tdata,
    // status
    output logic [kbh_pkg::STATUS_W-1:0]    m_tuser,
    output logic                            m_tlast,
    input  logic                            cfg_we,
    input  logic [kbh_pkg::K_CFG_W-1:0]     cfg_wdata
);

    logic [kbh_pkg::K_CFG_W-1:0]  k_in_use_reg;
    logic [CNT_W-1:0]             k_eff;
    logic                         in_valid;
    logic                         in_ready;
    kbh_pkg::kbh_cmd_t            cmd;
    kbh_pkg::kbh_stat_t           stat;
    logic [COORD_BITS-1:0]        out_x;
    logic [COORD_BITS-1:0]        out_y;
    logic [kbh_pkg::DIST_W-1:0]   out_d;

    // k register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_in_use_reg <= kbh_pkg::K_RESET;
        end
        else if (cfg_we)
        begin
            k_in_use_reg <= cfg_wdata;
        end
    end

    // k clamped to one through capacity
    always_comb
    begin
        if (k_in_use_reg == '0)
        begin
            k_eff = CNT_W'(1);
        end
        else if (32'(k_in_use_reg) > MAX_K)
        begin
            k_eff = CNT_W'(MAX_K);
        end
        else
        begin
            k_eff = CNT_W'(k_in_use_reg);
        end
    end

    assign in_valid = s_tvalid;
    assign s_tready = in_ready;

    kbh_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    kbh_datapath #(
        .MAX_K      (MAX_K),
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .k_eff      (k_eff),
        .in_op      (s_tuser[kbh_pkg::OP_W-1:0]),
        .in_x       (s_tdata[COORD_BITS-1:0]),
        .in_y       (s_tdata[2*COORD_BITS-1:COORD_BITS]),
        .in_d       (s_tdata[2*COORD_BITS +: kbh_pkg::DIST_W]),
        .in_usable  (s_tuser[kbh_pkg::OP_W]),
        .cmd        (cmd),
        .stat       (stat),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_status (m_tuser),
        .out_x      (out_x),
        .out_y      (out_y),
        .out_d      (out_d),
        .out_last   (m_tlast)
    );

    // result packing, first field lowest
    assign m_tdata = OUT_DATA_W'({out_d, out_y, out_x});

endmodule

// ===== dv/k_best_candidate_heap_core_test.sv =====
// self-checking testbench for the k-best candidate heap core
module k_best_candidate_heap_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HEAP_DEPTH     = 16;
    localparam int XY_W           = 12;
    localparam int PLAN_ROWS      = 24;
    localparam int RANDOM_ITEMS   = 240;
    localparam int IDLE_GAP       = 40;     // covers a drain of an empty heap
    localparam int HOLD_CYCLES    = 250;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int REPORT_MAX     = 10;

    typedef logic [kbh_pkg::OP_W-1:0]    op_t;
    typedef logic [kbh_pkg::K_CFG_W-1:0] k_val_t;
    typedef logic [XY_W-1:0]             coord_t;

    // one input item
    typedef struct packed {
        logic [kbh_pkg::OP_W-1:0]   op;
        logic [XY_W-1:0]            x;
        logic [XY_W-1:0]            y;
        logic [kbh_pkg::DIST_W-1:0] sqdist;
        logic                       usable;
    } cand_t;

    // one result item
    typedef struct packed {
        logic [kbh_pkg::STATUS_W-1:0] status;
        logic [XY_W-1:0]              x;
        logic [XY_W-1:0]              y;
        logic [kbh_pkg::DIST_W-1:0]   sqdist;
        logic                         last;
    } heap_res_t;

    // directed row: optional k write before the item, optional typed-in status
    typedef struct packed {
        logic                         set_k;
        logic [kbh_pkg::K_CFG_W-1:0]  k_val;
        logic                         typed;
        logic [kbh_pkg::STATUS_W-1:0] status;
        cand_t                        cand;
    } plan_row_t;

    localparam plan_row_t PLAN [PLAN_ROWS] = '{
        // empty heap drains to nothing
        '{1'b0, 5'd0, 1'b0, kbh_pkg::ST_ACCEPTED,
          '{kbh_pkg::OP_DRAIN, 12'd0, 12'd0, 32'd0, 1'b1}},
        '{1'b0, 5'd0, 1'b1, kbh_pkg::ST_ACCEPTED,
          '{kbh_pkg::OP_START, 12'd0, 12'd0, 32'd0, 1'b1}},
        '{1'b0, 5'd0, 1'b1, kbh_pkg::ST_ACCEPTED,
          '{kbh_pkg::OP_FILL, 12'd0, 12'd0, 32'd0, 1'b1}},
        '{1'b0, 5'd0, 1'b1, kbh_pkg::ST_ACCEPTED,
          '{kbh_pkg::OP_FILL, 12'd4095, 12'd4095, 32'hFFFF_FFFF, 1'b1}},
        '{1'b0, 5'd0, 1'b1, kbh_pkg::ST_DUPLICATE,
          '{kbh_pkg::OP_FILL, 12'd4095, 12'd4095, 32'd5, 1'b1}},
        '{1'b0, 5'd0, 1'b1, kbh_pkg::ST_UNUSABLE,
          '{kbh_pkg::OP_FILL, 12'd4095, 12'd0, 32'd9, 1'b0}},
        '{1'b0, 5'd0, 1'b1, kbh_pkg::ST_DUPLICATE,
          '{kbh_pkg::OP_ATTEMPT, 12'd0, 12'd0, 32'd3, 1'b1}},
        '{1'b0, 5'd0, 1'b1, kbh_pkg::ST_UNUSABLE,
          '{kbh_pkg::OP_ATTEMPT, 12'd0, 12'd4095, 32'd3, 1'b0}},
        '{1'b0, 5'd0, 1'b1, kbh_pkg::ST_ACCEPTED,
          '{kbh_pkg::OP_ATTEMPT, 12'd1, 12'd2, 32'h8000_0000, 1'b1}},
        // equal distances exercise the tie rules of both sifts
        '{1'b0, 5'd0, 1'b0, kbh_pkg::ST_ACCEPTED,
          '{kbh_pkg::OP_FILL, 12'd5, 12'd5, 32'd1000, 1'b1}},
        '{1'b0, 5'd0, 1'b0, kbh_pkg::ST_ACCEPTED,
          '{kbh_pkg::OP_FILL, 12'd6, 12'd6, 32'd1000, 1'b1}},
        '{1'b0, 5'd0, 1'b0, kbh_pkg::ST_ACCEPTED,
          '{kbh_pkg::OP_ATTEMPT, 12'd7, 12'd8, 32'd1000, 1'b1}},
        '{1'b0, 5'd0, 1'b0, kbh_pkg::ST_ACCEPTED,
          '{kbh_pkg::OP_DRAIN, 12'd0, 12'd0, 32'd0, 1'b1}},
        // k lowered below the fill level: full, but the root can still be replaced
        '{1'b1, 5'd3, 1'b1, kbh_pkg::ST_FULL,
          '{kbh_pkg::OP_FILL, 12'd9, 12'd9, 32'd1, 1'b1}},
        '{1'b0, 5'd0, 1'b1, kbh_pkg::ST_NOT_CLOSER,
          '{kbh_pkg::OP_ATTEMPT, 12'd10, 12'd10, 32'hFFFF_FFFF, 1'b1}},
        '{1'b0, 5'd0, 1'b0, kbh_pkg::ST_ACCEPTED,
          '{kbh_pkg::OP_ATTEMPT, 12'd11, 12'd11, 32'd2, 1'b1}},
        '{1'b0, 5'd0, 1'b0, kbh_pkg::ST_ACCEPTED,
          '{kbh_pkg::OP_DRAIN, 12'd0, 12'd0, 32'd0, 1'b1}},
        // k of zero acts as one
        '{1'b1, 5'd0, 1'b1, kbh_pkg::ST_ACCEPTED,
          '{kbh_pkg::OP_START, 12'd0, 12'd0, 32'd0, 1'b1}},
        '{1'b0, 5'd0, 1'b1, kbh_pkg::ST_ACCEPTED,
          '{kbh_pkg::OP_FILL, 12'd1, 12'd1, 32'd50, 1'b1}},
        '{1'b0, 5'd0, 1'b1, kbh_pkg::ST_FULL,
          '{kbh_pkg::OP_FILL, 12'd2, 12'd2, 32'd10, 1'b1}},
        '{1'b0, 5'd0, 1'b1, kbh_pkg::ST_NOT_CLOSER,
          '{kbh_pkg::OP_ATTEMPT, 12'd3, 12'd3, 32'd60, 1'b1}},
        '{1'b0, 5'd0, 1'b1, kbh_pkg::ST_ACCEPTED,
          '{kbh_pkg::OP_ATTEMPT, 12'd3, 12'd3, 32'd49, 1'b1}},
        '{1'b0, 5'd0, 1'b0, kbh_pkg::ST_ACCEPTED,
          '{kbh_pkg::OP_DRAIN, 12'd0, 12'd0, 32'd0, 1'b1}},
        // k above the heap depth acts as the depth
        '{1'b1, 5'd31, 1'b1, kbh_pkg::ST_ACCEPTED,
          '{kbh_pkg::OP_START, 12'd0, 12'd0, 32'd0, 1'b1}}
    };

    logic                          clk;
    logic                          rst_n     = 1'b0;
    logic                          s_tvalid  = 1'b0;
    logic                          s_tready;
    // cand_x, cand_y, cand_distance
    logic [55:0]                   s_tdata   = '0;
    // operation, cand_usable
    logic [kbh_pkg::IN_USER_W-1:0] s_tuser   = '0;
    logic                          m_tvalid;
    logic                          m_tready  = 1'b0;
    // entry_x, entry_y, entry_distance
    logic [55:0]                   m_tdata;
    // status
    logic [kbh_pkg::STATUS_W-1:0]  m_tuser;
    logic                          m_tlast;
    logic                          cfg_we    = 1'b0;
    logic [kbh_pkg::K_CFG_W-1:0]   cfg_wdata = '0;

    // predicted heap contents and k register
    logic [kbh_pkg::DIST_W-1:0]    kept_dist [HEAP_DEPTH];
    logic [XY_W-1:0]               kept_x [HEAP_DEPTH];
    logic [XY_W-1:0]               kept_y [HEAP_DEPTH];
    int                            kept_count;
    logic [kbh_pkg::K_CFG_W-1:0]   k_setting;

    heap_res_t            due_results [$];
    heap_res_t            step_out [$];

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_reqs     = 0;
    int hold_seen     = 0;
    int hold_left     = 0;
    int quiet_cycles  = 0;
    int mismatches    = 0;
    int items_sent    = 0;
    int results_seen  = 0;
    int entries_seen  = 0;
    int k_writes      = 0;

    k_best_candidate_heap_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // 100 MHz clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // k as the heap uses it
    function automatic int effective_k();
        if (k_setting == 0)
            return 1;
        if (int'(k_setting) > HEAP_DEPTH)
            return HEAP_DEPTH;
        return int'(k_setting);
    endfunction

    function automatic void heap_swap(input int a, input int b);
        logic [kbh_pkg::DIST_W-1:0] td;
        logic [XY_W-1:0]            tx;
        logic [XY_W-1:0]            ty;
        td = kept_dist[a]; kept_dist[a] = kept_dist[b]; kept_dist[b] = td;
        tx = kept_x[a];    kept_x[a]    = kept_x[b];    kept_x[b]    = tx;
        ty = kept_y[a];    kept_y[a]    = kept_y[b];    kept_y[b]    = ty;
    endfunction

    // append at the end, sift up while the parent is strictly smaller
    function automatic void heap_insert(input cand_t c);
        int n;
        if (kept_count >= HEAP_DEPTH)
            return;
        n = kept_count;
        kept_dist[n] = c.sqdist;
        kept_x[n]    = c.x;
        kept_y[n]    = c.y;
        kept_count   = n + 1;
        while (n > 0 && kept_dist[(n - 1) / 2] < kept_dist[n])
        begin
            heap_swap((n - 1) / 2, n);
            n = (n - 1) / 2;
        end
    endfunction

    // last entry to the root, sift down toward the strictly larger child
    function automatic void heap_drop_root();
        int n;
        int pick;
        kept_count   = kept_count - 1;
        kept_dist[0] = kept_dist[kept_count];
        kept_x[0]    = kept_x[kept_count];
        kept_y[0]    = kept_y[kept_count];
        n = 0;
        while (2 * n + 1 < kept_count)
        begin
            pick = n;
            if (kept_dist[n] < kept_dist[2 * n + 1])
                pick = 2 * n + 1;
            if (2 * n + 2 < kept_count && kept_dist[pick] < kept_dist[2 * n + 2])
                pick = 2 * n + 2;
            if (pick == n)
                break;
            heap_swap(n, pick);
            n = pick;
        end
    endfunction

    function automatic bit heap_holds(input logic [XY_W-1:0] x, input logic [XY_W-1:0] y);
        for (int n = 0; n < kept_count; n++)
            if (kept_x[n] == x && kept_y[n] == y)
                return 1'b1;
        return 1'b0;
    endfunction

    // results of one item into step_out, heap state updated
    function automatic void predict_heap(input cand_t c);
        logic [kbh_pkg::STATUS_W-1:0] st;
        heap_res_t                    r;
        step_out.delete();
        if (c.op == kbh_pkg::OP_DRAIN)
        begin
            for (int n = 0; n < kept_count; n++)
            begin
                r = '{kbh_pkg::ST_ENTRY, kept_x[n], kept_y[n], kept_dist[n],
                      n + 1 == kept_count};
                step_out.push_back(r);
            end
            return;
        end
        st = kbh_pkg::ST_ACCEPTED;
        if (c.op == kbh_pkg::OP_START)
            kept_count = 0;
        else if (heap_holds(c.x, c.y))
            st = kbh_pkg::ST_DUPLICATE;
        else if (!c.usable)
            st = kbh_pkg::ST_UNUSABLE;
        else if (kept_count < effective_k())
            heap_insert(c);
        else if (c.op == kbh_pkg::OP_FILL)
            st = kbh_pkg::ST_FULL;
        else if (c.sqdist < kept_dist[0])
        begin
            heap_drop_root();
            heap_insert(c);
        end
        else
            st = kbh_pkg::ST_NOT_CLOSER;
        r = '{st, 12'd0, 12'd0, 32'd0, 1'b1};
        step_out.push_back(r);
    endfunction

    // random candidate: half from a small coordinate pool so duplicates occur
    function automatic cand_t make_cand(input logic [kbh_pkg::OP_W-1:0] op);
        cand_t c;
        c.op = op;
        if ($urandom_range(1) == 1)
        begin
            c.x = coord_t'($urandom_range(7));
            c.y = coord_t'($urandom_range(7));
        end
        else
        begin
            c.x = coord_t'($urandom_range(4095));
            c.y = coord_t'($urandom_range(4095));
        end
        case ($urandom_range(3))
            0:       c.sqdist = $urandom_range(3);
            1:       c.sqdist = ($urandom_range(1) == 1) ? 32'hFFFF_FFFF : 32'h0;
            default: c.sqdist = $urandom();
        endcase
        c.usable = ($urandom_range(9) != 0);
        return c;
    endfunction

    // offer one item, predict at the accepting edge
    task automatic push_item(input cand_t c, input bit typed = 1'b0,
                             input logic [kbh_pkg::STATUS_W-1:0] st = kbh_pkg::ST_ACCEPTED);
        int        gap;
        heap_res_t r;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {c.sqdist, c.y, c.x};
        s_tuser  <= {c.usable, c.op};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_heap(c);
        if (typed)
        begin
            r = '{st, 12'd0, 12'd0, 32'd0, 1'b1};
            due_results.push_back(r);
        end
        else
            foreach (step_out[i])
                due_results.push_back(step_out[i]);
        items_sent++;
    endtask

    // stop sending, let every result out, then give the core time to go idle
    task automatic settle();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (due_results.size() != 0);
        repeat (IDLE_GAP) @(posedge clk);
    endtask

    task automatic write_k(input logic [kbh_pkg::K_CFG_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        k_setting = v;
        k_writes++;
    endtask

    // result side: check each transfer, then pick next tready
    always @(posedge clk)
    begin : result_check
        heap_res_t got;
        heap_res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = '{m_tuser, m_tdata[11:0], m_tdata[23:12], m_tdata[55:24], m_tlast};
            results_seen++;
            if (got.status == kbh_pkg::ST_ENTRY)
                entries_seen++;
            if (due_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("%0t unexpected result: status %0d x %0d y %0d dist %h last %0d",
                             $realtime, got.status, got.x, got.y, got.sqdist, got.last);
            end
            else
            begin
                want = due_results.pop_front();
                if (got.status !== want.status || got.x !== want.x || got.y !== want.y ||
                    got.sqdist !== want.sqdist || got.last !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display({"%0t mismatch: exp status %0d x %0d y %0d dist %h ",
                                  "last %0d, got status %0d x %0d y %0d dist %h last %0d"},
                                 $realtime, want.status, want.x, want.y, want.sqdist,
                                 want.last, got.status, got.x, got.y, got.sqdist, got.last);
                end
            end
        end
        // long hold-off on request, otherwise random stalls
        if (hold_left > 0)
        begin
            m_tready  <= 1'b0;
            hold_left = hold_left - 1;
        end
        else if (hold_seen != hold_reqs)
        begin
            hold_seen = hold_seen + 1;
            hold_left = HOLD_CYCLES;
            m_tready  <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t no transfer for %0d cycles, %0d results still due",
                     $realtime, WATCHDOG_LIMIT, due_results.size());
            $display("[k_best_candidate_heap_core] ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // stimulus
    initial
    begin : stimulus
        int                          ep;
        logic [kbh_pkg::K_CFG_W-1:0] kv;
        kept_count = 0;
        k_setting  = kbh_pkg::K_RESET;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed rows
        for (int i = 0; i < PLAN_ROWS; i++)
        begin
            if (PLAN[i].set_k)
            begin
                settle();
                write_k(PLAN[i].k_val);
            end
            push_item(PLAN[i].cand, PLAN[i].typed, PLAN[i].status);
        end

        // random episodes: start, fill, drain, attempts, drain, some noise
        ep = 0;
        while (items_sent < PLAN_ROWS + RANDOM_ITEMS)
        begin
            settle();
            case (ep % 4)
                0:       begin send_idle_pct = 0;  stall_pct <= 0;  end
                1:       begin send_idle_pct = 77; stall_pct <= 0;  end
                2:       begin send_idle_pct = 0;  stall_pct <= 77; end
                default: begin send_idle_pct = 6;  stall_pct <= 6;  end
            endcase
            case (ep % 6)
                0:       kv = 5'd16;
                1:       kv = 5'd1;
                2:       kv = k_val_t'($urandom_range(15, 2));
                3:       kv = k_val_t'($urandom_range(31, 17));
                4:       kv = k_val_t'($urandom_range(16, 1));
                default: kv = 5'd0;
            endcase
            write_k(kv);
            push_item(make_cand(kbh_pkg::OP_START));
            repeat ($urandom_range(effective_k() + 2, 1))
                push_item(make_cand(kbh_pkg::OP_FILL));
            // receiver holds off while items keep coming
            if (ep % 3 == 0)
                hold_reqs <= hold_reqs + 1;
            push_item(make_cand(kbh_pkg::OP_DRAIN));
            // lower k under the fill level
            if (ep % 3 == 2 && kept_count > 1)
            begin
                settle();
                write_k(k_val_t'($urandom_range(kept_count - 1, 1)));
            end
            repeat ($urandom_range(20, 8))
                push_item(make_cand(kbh_pkg::OP_ATTEMPT));
            // sender waits for every result before the drain
            if (ep % 2 == 1)
            begin
                s_tvalid <= 1'b0;
                do
                    @(posedge clk);
                while (due_results.size() != 0);
            end
            push_item(make_cand(kbh_pkg::OP_DRAIN));
            repeat (3)
                push_item(make_cand(op_t'($urandom_range(3))));
            ep++;
        end

        // wind down
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (due_results.size() != 0);
        repeat (IDLE_GAP) @(posedge clk);

        $display("covered %0d items (%0d directed, %0d random episodes), %0d k writes",
                 items_sent, PLAN_ROWS, ep, k_writes);
        $display("checked %0d results including %0d drained entries, %0d mismatches",
                 results_seen, entries_seen, mismatches);
        if (mismatches == 0)
            $display("[k_best_candidate_heap_core] OK");
        else
            $display("[k_best_candidate_heap_core] ERROR");
        $finish;
    end

endmodule
